// ===== hw/rtl/qrsbd_pkg.sv =====
// Package for the QR segment bitstream decoder.
// Holds the request and response types, the mode and status codes and the lookup functions.
// Depends on nothing.
package qrsbd_pkg;

   typedef struct packed {
      logic [7:0] code_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       is_status;
      logic [1:0] status_code;
      logic       end_of_output;
   } rsp_type;

   localparam logic [1:0] MODE_NUMERIC = 2'd1;
   localparam logic [1:0] MODE_ALNUM   = 2'd2;
   localparam logic [1:0] MODE_BYTE    = 2'd3;

   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_BAD_VALUE   = 2'd1;
   localparam logic [1:0] STATUS_UNSUPPORTED = 2'd2;
   localparam logic [1:0] STATUS_TRUNCATED   = 2'd3;

   localparam logic [3:0] HDR_TERMINATOR = 4'd0;
   localparam logic [3:0] HDR_NUMERIC    = 4'd1;
   localparam logic [3:0] HDR_ALNUM      = 4'd2;
   localparam logic [3:0] HDR_BYTE       = 4'd4;

   function automatic logic [4:0] count_width(input logic [5:0] version,
                                              input logic [1:0] mode);
      logic [1:0] tier;
      logic [4:0] w;
      tier = (version <= 6'd9) ? 2'd0 : ((version <= 6'd26) ? 2'd1 : 2'd2);
      case (mode)
         MODE_NUMERIC: w = 5'd10 + {2'b00, tier, 1'b0};
         MODE_ALNUM:   w = 5'd9 + {2'b00, tier, 1'b0};
         default:      w = (tier == 2'd0) ? 5'd8 : 5'd16;
      endcase
      return w;
   endfunction

   function automatic logic [7:0] alnum_char(input logic [5:0] idx);
      logic [7:0] c;
      if (idx <= 6'd9) begin
         c = 8'h30 + {2'b00, idx};
      end else if (idx <= 6'd35) begin
         c = 8'h37 + {2'b00, idx};
      end else begin
         case (idx)
            6'd36:   c = 8'h20;
            6'd37:   c = 8'h24;
            6'd38:   c = 8'h25;
            6'd39:   c = 8'h2a;
            6'd40:   c = 8'h2b;
            6'd41:   c = 8'h2d;
            6'd42:   c = 8'h2e;
            6'd43:   c = 8'h2f;
            6'd44:   c = 8'h3a;
            default: c = 8'h00;
         endcase
      end
      return c;
   endfunction

endpackage

// ===== hw/rtl/qr_segment_bitstream_decoder_core.sv =====
// QR segment bitstream decoder, top level.
// A request is accepted in idle and then runs parse steps; each data group passes the group
// check and conversion states before its characters are emitted as results; a rejected numeric
// or single alphanumeric group skips the conversion. The group conversion reuses one small
// constant multiplier. No request is taken until the previous one has finished; a stalled
// result holds the sequencer, but once six results of a request are out the rest are dropped.
// Synchronous active-high reset clears all parse state and sets the version to 1.
module qr_segment_bitstream_decoder_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  qrsbd_pkg::req_type   req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output qrsbd_pkg::rsp_type   rsp_data,
   input  logic                 csr_write_enable,
   input  logic [5:0]           csr_write_data
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_PARSE, ST_GROUP, ST_CONVERT, ST_EMIT, ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      PH_HEADER, PH_COUNT, PH_DATA, PH_STOPPED
   } phase_type;

   state_type          state_ff;
   phase_type          phase_ff;
   logic [5:0]         version_ff;
   logic [23:0]        acc_ff;
   logic [4:0]         held_ff;
   logic [1:0]         mode_ff;
   logic [15:0]        chars_ff;
   logic [1:0]         pending_ff;
   logic               last_ff;
   logic [2:0]         out_cnt_ff;
   logic [10:0]        grp_ff;
   logic [4:0]         grp_w_ff;
   logic [5:0]         hi_ff;
   logic [6:0]         lo_ff;
   logic [7:0]         buf_ff [3];
   logic [1:0]         buf_n_ff;
   logic [1:0]         buf_idx_ff;
   logic               rsp_valid_ff;
   qrsbd_pkg::rsp_type rsp_ff;

   logic [4:0]  need_w;
   logic [4:0]  rest;
   logic [23:0] shifted;
   logic [15:0] take_v;
   logic [23:0] acc_in;
   logic [10:0] mul_x;
   logic [10:0] mul_k;
   logic [21:0] product;
   logic        slot_free;
   logic        can_emit;
   logic        rsp_load;
   logic [3:0]  t_digit;
   logic [6:0]  u_digit;
   logic        grp_bad;
   logic        pair_bad;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign can_emit  = slot_free || (out_cnt_ff >= 3'd6);
   assign rsp_load  = can_emit && (out_cnt_ff < 3'd6) &&
                      ((state_ff == ST_EMIT) || (state_ff == ST_FINISH && last_ff));

   always_comb begin
      case (phase_ff)
         PH_HEADER: need_w = 5'd4;
         PH_COUNT:  need_w = qrsbd_pkg::count_width(version_ff, mode_ff);
         PH_DATA: begin
            if (mode_ff == qrsbd_pkg::MODE_NUMERIC) begin
               need_w = (chars_ff >= 16'd3) ? 5'd10 : ((chars_ff == 16'd2) ? 5'd7 : 5'd4);
            end else if (mode_ff == qrsbd_pkg::MODE_ALNUM) begin
               need_w = (chars_ff >= 16'd2) ? 5'd11 : 5'd6;
            end else begin
               need_w = 5'd8;
            end
         end
         default:   need_w = 5'd4;
      endcase
      rest    = held_ff - need_w;
      shifted = acc_ff >> rest;
      take_v  = shifted[15:0] & ((16'd1 << need_w) - 16'd1);
      acc_in  = acc_ff & ((24'd1 << rest) - 24'd1);
   end

   always_comb begin
      if (state_ff == ST_GROUP) begin
         mul_x = grp_ff;
         mul_k = (mode_ff == qrsbd_pkg::MODE_ALNUM) ? 11'd1457 : 11'd41;
      end else begin
         mul_x = {4'd0, lo_ff};
         mul_k = 11'd103;
      end
      product = {11'd0, mul_x} * {11'd0, mul_k};
      t_digit = product[13:10];
      u_digit = lo_ff - {t_digit, 3'd0} - {2'd0, t_digit, 1'b0};
      grp_bad = 1'b0;
      if (mode_ff == qrsbd_pkg::MODE_NUMERIC) begin
         grp_bad = (grp_w_ff == 5'd10 && grp_ff >= 11'd1000) ||
                   (grp_w_ff == 5'd7 && grp_ff >= 11'd100) ||
                   (grp_w_ff == 5'd4 && grp_ff >= 11'd10);
      end else if (mode_ff == qrsbd_pkg::MODE_ALNUM) begin
         grp_bad = (grp_w_ff == 5'd6) && (grp_ff >= 11'd45);
      end
      pair_bad = (mode_ff == qrsbd_pkg::MODE_ALNUM) && (grp_w_ff == 5'd11) &&
                 (hi_ff >= 6'd45);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_HEADER;
         version_ff   <= 6'd1;
         acc_ff       <= 24'd0;
         held_ff      <= 5'd0;
         mode_ff      <= 2'd0;
         chars_ff     <= 16'd0;
         pending_ff   <= qrsbd_pkg::STATUS_OK;
         rsp_valid_ff <= 1'b0;
         out_cnt_ff   <= 3'd0;
      end else begin
         if (csr_write_enable) begin
            version_ff <= csr_write_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  last_ff    <= req_data.final_byte;
                  out_cnt_ff <= 3'd0;
                  if (phase_ff != PH_STOPPED) begin
                     acc_ff  <= {acc_ff[15:0], req_data.code_byte};
                     held_ff <= held_ff + 5'd8;
                  end
                  state_ff <= ST_PARSE;
               end
            end
            ST_PARSE: begin
               if (phase_ff == PH_STOPPED || held_ff < need_w) begin
                  state_ff <= ST_FINISH;
               end else begin
                  acc_ff  <= acc_in;
                  held_ff <= rest;
                  case (phase_ff)
                     PH_HEADER: begin
                        case (take_v[3:0])
                           qrsbd_pkg::HDR_TERMINATOR: phase_ff <= PH_STOPPED;
                           qrsbd_pkg::HDR_NUMERIC: begin
                              mode_ff  <= qrsbd_pkg::MODE_NUMERIC;
                              phase_ff <= PH_COUNT;
                           end
                           qrsbd_pkg::HDR_ALNUM: begin
                              mode_ff  <= qrsbd_pkg::MODE_ALNUM;
                              phase_ff <= PH_COUNT;
                           end
                           qrsbd_pkg::HDR_BYTE: begin
                              mode_ff  <= qrsbd_pkg::MODE_BYTE;
                              phase_ff <= PH_COUNT;
                           end
                           default: begin
                              pending_ff <= qrsbd_pkg::STATUS_UNSUPPORTED;
                              phase_ff   <= PH_STOPPED;
                           end
                        endcase
                     end
                     PH_COUNT: begin
                        chars_ff <= take_v;
                        phase_ff <= (take_v != 16'd0) ? PH_DATA : PH_HEADER;
                     end
                     default: begin
                        grp_ff   <= take_v[10:0];
                        grp_w_ff <= need_w;
                        state_ff <= ST_GROUP;
                     end
                  endcase
               end
            end
            ST_GROUP: begin
               if (grp_bad) begin
                  pending_ff <= qrsbd_pkg::STATUS_BAD_VALUE;
                  phase_ff   <= PH_STOPPED;
                  state_ff   <= ST_PARSE;
               end else begin
                  state_ff   <= ST_CONVERT;
               end
               if (mode_ff == qrsbd_pkg::MODE_NUMERIC) begin
                  if (grp_w_ff == 5'd10) begin
                     hi_ff <= {2'd0, product[15:12]};
                     lo_ff <= 7'(grp_ff - 11'(product[15:12]) * 11'd100);
                  end else begin
                     hi_ff <= 6'd0;
                     lo_ff <= grp_ff[6:0];
                  end
               end else if (mode_ff == qrsbd_pkg::MODE_ALNUM) begin
                  if (grp_w_ff == 5'd11) begin
                     hi_ff <= product[21:16];
                     lo_ff <= 7'(grp_ff - 11'(product[21:16]) * 11'd45);
                  end else begin
                     hi_ff <= grp_ff[5:0];
                     lo_ff <= 7'd0;
                  end
               end
            end
            ST_CONVERT: begin
               buf_idx_ff <= 2'd0;
               state_ff   <= pair_bad ? ST_PARSE : ST_EMIT;
               if (mode_ff == qrsbd_pkg::MODE_NUMERIC) begin
                  if (grp_w_ff == 5'd10) begin
                     buf_ff[0] <= 8'h30 + {2'd0, hi_ff};
                     buf_ff[1] <= 8'h30 + {4'd0, t_digit};
                     buf_ff[2] <= 8'h30 + {1'b0, u_digit};
                     buf_n_ff  <= 2'd3;
                     chars_ff  <= chars_ff - 16'd3;
                     if (chars_ff == 16'd3) phase_ff <= PH_HEADER;
                  end else if (grp_w_ff == 5'd7) begin
                     buf_ff[0] <= 8'h30 + {4'd0, t_digit};
                     buf_ff[1] <= 8'h30 + {1'b0, u_digit};
                     buf_n_ff  <= 2'd2;
                     chars_ff  <= chars_ff - 16'd2;
                     if (chars_ff == 16'd2) phase_ff <= PH_HEADER;
                  end else begin
                     buf_ff[0] <= 8'h30 + {1'b0, lo_ff};
                     buf_n_ff  <= 2'd1;
                     chars_ff  <= chars_ff - 16'd1;
                     if (chars_ff == 16'd1) phase_ff <= PH_HEADER;
                  end
               end else if (mode_ff == qrsbd_pkg::MODE_ALNUM) begin
                  buf_ff[0] <= qrsbd_pkg::alnum_char(hi_ff);
                  if (grp_w_ff == 5'd11) begin
                     buf_ff[1] <= qrsbd_pkg::alnum_char(lo_ff[5:0]);
                     buf_n_ff  <= 2'd2;
                     if (pair_bad) begin
                        pending_ff <= qrsbd_pkg::STATUS_BAD_VALUE;
                        phase_ff   <= PH_STOPPED;
                     end else begin
                        chars_ff <= chars_ff - 16'd2;
                        if (chars_ff == 16'd2) phase_ff <= PH_HEADER;
                     end
                  end else begin
                     buf_n_ff <= 2'd1;
                     chars_ff <= chars_ff - 16'd1;
                     if (chars_ff == 16'd1) phase_ff <= PH_HEADER;
                  end
               end else begin
                  if (!grp_ff[7]) begin
                     buf_ff[0] <= grp_ff[7:0];
                     buf_n_ff  <= 2'd1;
                  end else begin
                     buf_ff[0] <= 8'hc0 | {6'd0, grp_ff[7:6]};
                     buf_ff[1] <= 8'h80 | {2'd0, grp_ff[5:0]};
                     buf_n_ff  <= 2'd2;
                  end
                  chars_ff <= chars_ff - 16'd1;
                  if (chars_ff == 16'd1) phase_ff <= PH_HEADER;
               end
            end
            ST_EMIT: begin
               if (can_emit) begin
                  if (out_cnt_ff < 3'd6) begin
                     rsp_ff.text_byte      <= buf_ff[buf_idx_ff];
                     rsp_ff.is_status      <= 1'b0;
                     rsp_ff.status_code    <= qrsbd_pkg::STATUS_OK;
                     rsp_ff.end_of_output  <= 1'b0;
                     out_cnt_ff            <= out_cnt_ff + 3'd1;
                  end
                  buf_idx_ff <= buf_idx_ff + 2'd1;
                  if (buf_idx_ff == buf_n_ff - 2'd1) begin
                     state_ff <= ST_PARSE;
                  end
               end
            end
            ST_FINISH: begin
               if (!last_ff) begin
                  state_ff <= ST_IDLE;
               end else if (can_emit) begin
                  if (out_cnt_ff < 3'd6) begin
                     rsp_ff.text_byte     <= 8'd0;
                     rsp_ff.is_status     <= 1'b1;
                     rsp_ff.end_of_output <= 1'b1;
                     if (phase_ff == PH_STOPPED) begin
                        rsp_ff.status_code <= pending_ff;
                     end else if (phase_ff == PH_HEADER) begin
                        rsp_ff.status_code <= qrsbd_pkg::STATUS_OK;
                     end else begin
                        rsp_ff.status_code <= qrsbd_pkg::STATUS_TRUNCATED;
                     end
                  end
                  acc_ff     <= 24'd0;
                  held_ff    <= 5'd0;
                  phase_ff   <= PH_HEADER;
                  mode_ff    <= 2'd0;
                  chars_ff   <= 16'd0;
                  pending_ff <= qrsbd_pkg::STATUS_OK;
                  state_ff   <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_status |-> rsp_data.end_of_output)
      else $error("Status response without end of output.");

   assert property (@(posedge clock) disable iff (reset)
      held_ff <= 5'd23)
      else $error("Bit accumulator overfilled.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled response changed.");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> buf_idx_ff < buf_n_ff)
      else $error("Emit index past buffered characters.");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the QR segment bitstream decoder core.
// Runs a directed table, then random well-formed and damaged symbols over several versions.
// Depends on qrsbd_pkg and qr_segment_bitstream_decoder_core.
module tb;

   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [2:0] {PH_HEADER, PH_COUNT, PH_DATA, PH_STOP} phase_type;

   typedef struct {
      logic [7:0] code;
      logic       fin;
      logic       typed;
      logic [1:0] status;
   } row_type;

   localparam string ALNUM_SET = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ $%*+-./:";
   localparam int DRAIN_CYCLES = 60;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   qrsbd_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   qrsbd_pkg::rsp_type rsp_data;
   logic    csr_write_enable = 1'b0;
   logic [5:0] csr_write_data = 6'd0;

   qrsbd_pkg::rsp_type text_expected[$];
   int        errors = 0;
   bit        quiet = 1'b0;
   int        stall_left = 0;

   logic [5:0]  cur_version;
   logic [23:0] acc;
   logic [4:0]  held;
   phase_type   phase;
   logic [1:0]  mode;
   logic [15:0] remaining;
   logic [1:0]  pend;
   int          step_results;

   bit      stream_bits[$];
   qrsbd_pkg::req_type symbol[$];

   qr_segment_bitstream_decoder_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int count_bits(logic [5:0] v, logic [1:0] m);
      int tier;
      tier = (v <= 9) ? 0 : ((v <= 26) ? 1 : 2);
      if (m == qrsbd_pkg::MODE_NUMERIC) return 10 + 2 * tier;
      if (m == qrsbd_pkg::MODE_ALNUM) return 9 + 2 * tier;
      return (tier == 0) ? 8 : 16;
   endfunction

   function automatic void clear_parse();
      acc = '0;
      held = '0;
      phase = PH_HEADER;
      mode = '0;
      remaining = '0;
      pend = qrsbd_pkg::STATUS_OK;
   endfunction

   function automatic void push_result(int t, logic s, logic [1:0] c, logic e);
      qrsbd_pkg::rsp_type r;
      if (step_results >= 6) return;
      r.text_byte = t[7:0];
      r.is_status = s;
      r.status_code = c;
      r.end_of_output = e;
      text_expected = {text_expected, r};
      step_results++;
   endfunction

   function automatic int pull(int n);
      int rest;
      int v;
      rest = held - n;
      v = (int'(acc) >> rest) & ((1 << n) - 1);
      held = rest[4:0];
      acc = acc & 24'((1 << rest) - 1);
      return v;
   endfunction

   function automatic void halt(logic [1:0] c);
      pend = c;
      phase = PH_STOP;
   endfunction

   function automatic void decode_group(int w, int v);
      if (mode == qrsbd_pkg::MODE_NUMERIC) begin
         if ((w == 10 && v >= 1000) || (w == 7 && v >= 100) || (w == 4 && v >= 10)) begin
            halt(qrsbd_pkg::STATUS_BAD_VALUE);
            return;
         end
         if (w == 10) push_result(8'h30 + v / 100, 0, qrsbd_pkg::STATUS_OK, 0);
         if (w >= 7) push_result(8'h30 + (v / 10) % 10, 0, qrsbd_pkg::STATUS_OK, 0);
         push_result(8'h30 + v % 10, 0, qrsbd_pkg::STATUS_OK, 0);
         remaining -= (w == 10) ? 3 : ((w == 7) ? 2 : 1);
      end else if (mode == qrsbd_pkg::MODE_ALNUM) begin
         if ((w == 11 && v / 45 >= 45) || (w == 6 && v >= 45)) begin
            halt(qrsbd_pkg::STATUS_BAD_VALUE);
            return;
         end
         if (w == 11) begin
            push_result(ALNUM_SET[v / 45], 0, qrsbd_pkg::STATUS_OK, 0);
            push_result(ALNUM_SET[v % 45], 0, qrsbd_pkg::STATUS_OK, 0);
            remaining -= 2;
         end else begin
            push_result(ALNUM_SET[v], 0, qrsbd_pkg::STATUS_OK, 0);
            remaining -= 1;
         end
      end else begin
         if (v < 8'h80) begin
            push_result(v, 0, qrsbd_pkg::STATUS_OK, 0);
         end else begin
            push_result(8'hc0 | (v >> 6), 0, qrsbd_pkg::STATUS_OK, 0);
            push_result(8'h80 | (v & 8'h3f), 0, qrsbd_pkg::STATUS_OK, 0);
         end
         remaining -= 1;
      end
      if (remaining == 0) phase = PH_HEADER;
   endfunction

   function automatic void decode_request(qrsbd_pkg::req_type r);
      bit going;
      int w;
      int h;
      step_results = 0;
      if (phase != PH_STOP) begin
         acc = {acc[15:0], r.code_byte};
         held = held + 5'd8;
         going = 1'b1;
         while (going) begin
            case (phase)
               PH_HEADER: begin
                  if (held < 4) begin
                     going = 1'b0;
                  end else begin
                     h = pull(4);
                     if (h == qrsbd_pkg::HDR_TERMINATOR) begin
                        phase = PH_STOP;
                     end else if (h == qrsbd_pkg::HDR_NUMERIC || h == qrsbd_pkg::HDR_ALNUM) begin
                        mode = h[1:0];
                        phase = PH_COUNT;
                     end else if (h == qrsbd_pkg::HDR_BYTE) begin
                        mode = qrsbd_pkg::MODE_BYTE;
                        phase = PH_COUNT;
                     end else begin
                        halt(qrsbd_pkg::STATUS_UNSUPPORTED);
                     end
                  end
               end
               PH_COUNT: begin
                  w = count_bits(cur_version, mode);
                  if (held < w) begin
                     going = 1'b0;
                  end else begin
                     remaining = pull(w);
                     phase = (remaining != 0) ? PH_DATA : PH_HEADER;
                  end
               end
               PH_DATA: begin
                  if (mode == qrsbd_pkg::MODE_NUMERIC)
                     w = (remaining >= 3) ? 10 : ((remaining == 2) ? 7 : 4);
                  else if (mode == qrsbd_pkg::MODE_ALNUM)
                     w = (remaining >= 2) ? 11 : 6;
                  else
                     w = 8;
                  if (held < w) going = 1'b0;
                  else decode_group(w, pull(w));
               end
               default: going = 1'b0;
            endcase
         end
      end
      if (r.final_byte) begin
         if (phase == PH_STOP) push_result(0, 1, pend, 1);
         else if (phase == PH_HEADER) push_result(0, 1, qrsbd_pkg::STATUS_OK, 1);
         else push_result(0, 1, qrsbd_pkg::STATUS_TRUNCATED, 1);
         clear_parse();
      end
   endfunction

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send(qrsbd_pkg::req_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      decode_request(r);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (text_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_version(logic [5:0] v);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cur_version = v;
   endtask

   function automatic void put(int unsigned v, int n);
      for (int i = n - 1; i >= 0; i--) stream_bits = {stream_bits, v[i]};
   endfunction

   function automatic int pick(int lo_max, int full_max);
      return ($urandom_range(0, 9) == 0) ? $urandom_range(0, full_max)
                                         : $urandom_range(0, lo_max);
   endfunction

   function automatic void build_symbol();
      int segs;
      int n;
      int c;
      int w;
      int k;
      logic [1:0] m;
      qrsbd_pkg::req_type r;
      stream_bits.delete();
      symbol.delete();
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 4);
         for (int i = 0; i < n; i++) put($urandom_range(0, 255), 8);
      end else begin
         segs = $urandom_range(1, 3);
         for (int s = 0; s < segs; s++) begin
            if ($urandom_range(0, 19) == 0) begin
               put($urandom_range(0, 15), 4);
               break;
            end
            k = $urandom_range(0, 2);
            m = (k == 0) ? qrsbd_pkg::MODE_NUMERIC
                         : ((k == 1) ? qrsbd_pkg::MODE_ALNUM : qrsbd_pkg::MODE_BYTE);
            put((m == qrsbd_pkg::MODE_BYTE) ? qrsbd_pkg::HDR_BYTE : m, 4);
            w = count_bits(cur_version, m);
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(0, (1 << w) - 1)
                                             : $urandom_range(0, 6);
            put(n, w);
            c = (n > 8) ? 8 : n;
            if (m == qrsbd_pkg::MODE_NUMERIC) begin
               for (; c >= 3; c -= 3) put(pick(999, 1023), 10);
               if (c == 2) put(pick(99, 127), 7);
               if (c == 1) put(pick(9, 15), 4);
            end else if (m == qrsbd_pkg::MODE_ALNUM) begin
               for (; c >= 2; c -= 2) put(pick(2024, 2047), 11);
               if (c == 1) put(pick(44, 63), 6);
            end else begin
               for (; c > 0; c--) put($urandom_range(0, 255), 8);
            end
         end
         if ($urandom_range(0, 9) < 7) put(0, 4);
         while (stream_bits.size() % 8 != 0) put(($urandom_range(0, 4) == 0), 1);
         if ($urandom_range(0, 4) == 0) put($urandom_range(0, 255), 8);
         if ($urandom_range(0, 9) == 0)
            stream_bits[$urandom_range(0, stream_bits.size() - 1)] ^= 1'b1;
         if ($urandom_range(0, 9) == 0 && stream_bits.size() > 8)
            repeat (8 * $urandom_range(1, stream_bits.size() / 8 - 1)) stream_bits.pop_back();
      end
      for (int i = 0; i < stream_bits.size(); i += 8) begin
         for (int b = 0; b < 8; b++) r.code_byte[7 - b] = stream_bits[i + b];
         r.final_byte = (i + 8 >= stream_bits.size());
         symbol = {symbol, r};
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (text_expected.size() == 0) begin
            $error("unexpected result %p", rsp_data);
            errors++;
         end else begin
            qrsbd_pkg::rsp_type e;
            e = text_expected.pop_front();
            if (rsp_data.text_byte !== e.text_byte) begin
               $error("text_byte expected %h actual %h", e.text_byte, rsp_data.text_byte);
               errors++;
            end
            if (rsp_data.is_status !== e.is_status) begin
               $error("is_status expected %b actual %b", e.is_status, rsp_data.is_status);
               errors++;
            end
            if (rsp_data.status_code !== e.status_code) begin
               $error("status_code expected %0d actual %0d", e.status_code,
                      rsp_data.status_code);
               errors++;
            end
            if (rsp_data.end_of_output !== e.end_of_output) begin
               $error("end_of_output expected %b actual %b", e.end_of_output,
                      rsp_data.end_of_output);
               errors++;
            end
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < 25) begin
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                  : $urandom_range(0, 2);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      row_type rows[$];
      qrsbd_pkg::req_type r;
      int sent;
      int k;
      int versions[8];

      versions = '{1, 40, 9, 10, 26, 27, 0, 63};

      // Numeric "0123456", alphanumeric "AC-", byte 0xff and 'A', then error cases.
      rows = '{
         '{8'h10, 0, 0, qrsbd_pkg::STATUS_OK}, '{8'h1c, 0, 0, qrsbd_pkg::STATUS_OK},
         '{8'h0c, 0, 0, qrsbd_pkg::STATUS_OK}, '{8'h56, 0, 0, qrsbd_pkg::STATUS_OK},
         '{8'h58, 0, 0, qrsbd_pkg::STATUS_OK}, '{8'h00, 1, 1, qrsbd_pkg::STATUS_OK},
         '{8'h20, 0, 0, qrsbd_pkg::STATUS_OK}, '{8'h19, 0, 0, qrsbd_pkg::STATUS_OK},
         '{8'hce, 0, 0, qrsbd_pkg::STATUS_OK}, '{8'ha4, 0, 0, qrsbd_pkg::STATUS_OK},
         '{8'h00, 1, 1, qrsbd_pkg::STATUS_OK},
         '{8'h40, 0, 0, qrsbd_pkg::STATUS_OK}, '{8'h2f, 0, 0, qrsbd_pkg::STATUS_OK},
         '{8'hf4, 0, 0, qrsbd_pkg::STATUS_OK}, '{8'h10, 0, 0, qrsbd_pkg::STATUS_OK},
         '{8'h00, 1, 1, qrsbd_pkg::STATUS_OK},
         '{8'h70, 1, 1, qrsbd_pkg::STATUS_UNSUPPORTED},
         '{8'hff, 1, 1, qrsbd_pkg::STATUS_UNSUPPORTED},
         '{8'h10, 0, 0, qrsbd_pkg::STATUS_OK}, '{8'h07, 0, 0, qrsbd_pkg::STATUS_OK},
         '{8'hc0, 1, 1, qrsbd_pkg::STATUS_BAD_VALUE},
         '{8'h10, 1, 1, qrsbd_pkg::STATUS_TRUNCATED},
         '{8'h00, 1, 1, qrsbd_pkg::STATUS_OK}
      };

      cur_version = 6'd1;
      clear_parse();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         r.code_byte = rows[i].code;
         r.final_byte = rows[i].fin;
         send(r);
         if (rows[i].typed && text_expected[$].status_code != rows[i].status) begin
            $error("status_code expected %0d predicted %0d at row %0d", rows[i].status,
                   text_expected[$].status_code, i);
            errors++;
         end
      end

      sent = rows.size();
      k = 0;
      while (sent < 130) begin
         set_version((k < 8) ? versions[k] : $urandom_range(0, 63));
         quiet = (k % 4 == 3);
         repeat (3) begin
            if (sent < 130) begin
               build_symbol();
               foreach (symbol[i]) send(symbol[i]);
               sent += symbol.size();
            end
         end
         k++;
      end
      quiet = 1'b0;

      wait_idle();
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
